### design/bsc_pkg.sv
// Shared types and constants for the banker's safety checker.
package bsc_pkg;

    localparam int CUST_W      = 3;
    localparam int CNT_W       = 4;
    localparam int IN_AMT_W    = 8;
    localparam int AVAIL_REGS  = 4;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 8;
    localparam int S_TDATA_W   = 40;
    localparam int S_TUSER_W   = 2;
    localparam int M_TDATA_W   = 8;
    localparam int M_TUSER_W   = 3;
    localparam int AMT_OFFSET  = 3;

    localparam logic [1:0] CMD_LOAD_MAX = 2'd0;
    localparam logic [1:0] CMD_REQUEST  = 2'd1;
    localparam logic [1:0] CMD_RELEASE  = 2'd2;
    localparam logic [1:0] CMD_UNUSED   = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_CUST  = 2'd1;
    localparam logic [1:0] ST_OVER_REL  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_AVAIL0    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AVAIL1    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AVAIL2    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_AVAIL3    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CUSTOMERS = 3'd4;

    localparam logic [CNT_W-1:0] CUST_RESET = 4'd8;

    typedef logic [AVAIL_REGS-1:0][CFG_DATA_W-1:0] avail_t;

    typedef struct packed {
        logic load_item;
        logic exec;
        logic scan_step;
        logic out_load;
        logic out_seq;
    } bsc_cmd_t;

    typedef struct packed {
        logic [1:0] command;
        logic       pass_end;
        logic       done_now;
        logic       progress_now;
        logic       emit_last;
        logic       out_free;
    } bsc_stat_t;

endpackage

### design/bsc_ctrl.sv
// Controller state machine for the banker's safety checker.
module bsc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  bsc_pkg::bsc_stat_t  stat,
    output bsc_pkg::bsc_cmd_t   cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       seq_mode_reg;
    logic       seq_mode_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            seq_mode_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            seq_mode_reg <= seq_mode_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        seq_mode_next = seq_mode_reg;
        cmd           = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
                case (stat.command)
                    bsc_pkg::CMD_LOAD_MAX:
                    begin
                        seq_mode_next = 1'b0;
                        state_next    = S_EMIT;
                    end
                    bsc_pkg::CMD_REQUEST, bsc_pkg::CMD_RELEASE:
                    begin
                        state_next = S_SCAN;
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.done_now)
                begin
                    seq_mode_next = 1'b1;
                    state_next    = S_EMIT;
                end
                else if (stat.pass_end && !stat.progress_now)
                begin
                    seq_mode_next = 1'b0;
                    state_next    = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_seq  = seq_mode_reg;
                    if (!seq_mode_reg || stat.emit_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

### design/bsc_datapath.sv
// Tables, work vector, sequence store and result register of the safety checker.
module bsc_datapath #(
    parameter int ROWS          = 8,
    parameter int NUM_RESOURCES = 4,
    parameter int AMOUNT_BITS   = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  bsc_pkg::bsc_cmd_t                   cmd,
    output bsc_pkg::bsc_stat_t                  stat,
    input  logic [bsc_pkg::S_TDATA_W-1:0]       in_tdata,
    input  logic [bsc_pkg::S_TUSER_W-1:0]       in_tuser,
    input  bsc_pkg::avail_t                     avail,
    input  logic [bsc_pkg::CNT_W-1:0]           active_n,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [bsc_pkg::M_TDATA_W-1:0]       out_tdata,
    output logic [bsc_pkg::M_TUSER_W-1:0]       out_tuser,
    output logic                                out_tlast
);

    localparam int A  = AMOUNT_BITS;
    localparam int NR = NUM_RESOURCES;
    localparam int WW = AMOUNT_BITS + 3;
    localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CW = bsc_pkg::CUST_W;
    localparam int NW = bsc_pkg::CNT_W;

    logic        [A-1:0] max_reg   [ROWS][NR];
    logic        [A-1:0] alloc_reg [ROWS][NR];
    logic signed [A:0]   need_reg  [ROWS][NR];
    logic        [WW-1:0] work_reg [NR];
    logic        [ROWS-1:0] fin_reg;
    logic        [CW-1:0] seq_reg  [ROWS];

    logic [1:0]    cmd_q_reg;
    logic [CW-1:0] cust_q_reg;
    logic [A-1:0]  amt_q_reg [NR];
    logic [1:0]    st_reg;

    logic [NW-1:0] count_reg;
    logic [CW-1:0] scan_reg;
    logic          progress_reg;
    logic [CW-1:0] emit_pos_reg;

    logic          out_valid_reg;
    logic [1:0]    out_status_reg;
    logic          out_safe_reg;
    logic [CW-1:0] out_pos_reg;
    logic [CW-1:0] out_cust_reg;
    logic          out_last_reg;

    logic [RW-1:0]       row_sel;
    logic [RW-1:0]       wr_row;
    logic                cust_ok;
    logic        [A-1:0] new_max   [NR];
    logic        [A-1:0] new_alloc [NR];
    logic signed [A:0]   new_need  [NR];
    logic signed [A:0]   diff_req  [NR];
    logic        [A-1:0] rel_alloc [NR];
    logic                ok_run;
    logic                rel_fail;
    logic [1:0]          st_new;
    logic                fit_res;
    logic                fits;
    logic [WW:0]         wsum      [NR];
    logic [WW-1:0]       work_new  [NR];
    logic [NW-1:0]       count_next;
    logic                out_free;
    logic                emit_last;

    assign cust_ok = ({1'b0, cust_q_reg} < active_n);
    assign wr_row  = cust_q_reg[RW-1:0];
    assign row_sel = cmd.exec ? cust_q_reg[RW-1:0] : scan_reg[RW-1:0];

    always_comb
    begin
        ok_run   = 1'b1;
        rel_fail = 1'b0;
        for (int j = 0; j < NR; j++)
        begin
            new_max[j]   = max_reg[row_sel][j];
            new_alloc[j] = alloc_reg[row_sel][j];
            new_need[j]  = need_reg[row_sel][j];
            diff_req[j]  = $signed({1'b0, max_reg[row_sel][j]})
                         - $signed({1'b0, amt_q_reg[j]});
            rel_alloc[j] = alloc_reg[row_sel][j] - amt_q_reg[j];
            case (cmd_q_reg)
                bsc_pkg::CMD_LOAD_MAX:
                begin
                    new_max[j] = amt_q_reg[j];
                end
                bsc_pkg::CMD_REQUEST:
                begin
                    new_alloc[j] = amt_q_reg[j];
                    new_need[j]  = diff_req[j][A] ? '0 : diff_req[j];
                end
                bsc_pkg::CMD_RELEASE:
                begin
                    if (ok_run)
                    begin
                        if (amt_q_reg[j] <= alloc_reg[row_sel][j])
                        begin
                            new_alloc[j] = rel_alloc[j];
                            new_need[j]  = $signed({1'b0, max_reg[row_sel][j]})
                                         - $signed({1'b0, rel_alloc[j]});
                        end
                        else
                        begin
                            ok_run   = 1'b0;
                            rel_fail = 1'b1;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
        if (!cust_ok)
            st_new = bsc_pkg::ST_BAD_CUST;
        else if (cmd_q_reg == bsc_pkg::CMD_RELEASE && rel_fail)
            st_new = bsc_pkg::ST_OVER_REL;
        else
            st_new = bsc_pkg::ST_OK;
    end

    always_comb
    begin
        fit_res = 1'b1;
        for (int j = 0; j < NR; j++)
        begin
            if ($signed({{3{need_reg[row_sel][j][A]}}, need_reg[row_sel][j]})
                > $signed({1'b0, work_reg[j]}))
                fit_res = 1'b0;
            wsum[j]     = {1'b0, work_reg[j]} + (WW+1)'(alloc_reg[row_sel][j]);
            work_new[j] = wsum[j][WW] ? '1 : wsum[j][WW-1:0];
        end
        fits = !fin_reg[row_sel] && fit_res;
    end

    assign count_next = count_reg + NW'(fits);
    assign out_free   = !out_valid_reg || out_ready;
    assign emit_last  = (({1'b0, emit_pos_reg} + NW'(1)) == active_n);

    assign stat.command      = cmd_q_reg;
    assign stat.pass_end     = (({1'b0, scan_reg} + NW'(1)) == active_n);
    assign stat.done_now     = (count_next == active_n);
    assign stat.progress_now = progress_reg || fits;
    assign stat.emit_last    = emit_last;
    assign stat.out_free     = out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < ROWS; r++)
            begin
                for (int j = 0; j < NR; j++)
                begin
                    max_reg[r][j]   <= '0;
                    alloc_reg[r][j] <= '0;
                    need_reg[r][j]  <= '0;
                end
            end
            for (int j = 0; j < NR; j++)
                work_reg[j] <= '0;
            fin_reg       <= '0;
            count_reg     <= '0;
            scan_reg      <= '0;
            progress_reg  <= 1'b0;
            emit_pos_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.exec)
            begin
                if (cust_ok)
                begin
                    for (int j = 0; j < NR; j++)
                    begin
                        max_reg[wr_row][j]   <= new_max[j];
                        alloc_reg[wr_row][j] <= new_alloc[j];
                        need_reg[wr_row][j]  <= new_need[j];
                    end
                end
                for (int j = 0; j < NR; j++)
                    work_reg[j] <= WW'(A'(avail[j]));
                fin_reg      <= '0;
                count_reg    <= '0;
                scan_reg     <= '0;
                progress_reg <= 1'b0;
                emit_pos_reg <= '0;
            end
            if (cmd.scan_step)
            begin
                if (fits)
                begin
                    fin_reg[row_sel] <= 1'b1;
                    for (int j = 0; j < NR; j++)
                        work_reg[j] <= work_new[j];
                end
                count_reg <= count_next;
                if (stat.pass_end)
                begin
                    scan_reg     <= '0;
                    progress_reg <= 1'b0;
                end
                else
                begin
                    scan_reg     <= scan_reg + CW'(1);
                    progress_reg <= stat.progress_now;
                end
            end
            if (cmd.out_load && cmd.out_seq)
                emit_pos_reg <= emit_pos_reg + CW'(1);
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            cmd_q_reg  <= in_tuser[1:0];
            cust_q_reg <= in_tdata[CW-1:0];
            for (int j = 0; j < NR; j++)
                amt_q_reg[j] <= A'(in_tdata[bsc_pkg::AMT_OFFSET + bsc_pkg::IN_AMT_W*j
                                            +: bsc_pkg::IN_AMT_W]);
        end
        if (cmd.exec)
            st_reg <= st_new;
        if (cmd.scan_step && fits)
            seq_reg[count_reg[RW-1:0]] <= scan_reg;
        if (cmd.out_load)
        begin
            out_status_reg <= st_reg;
            out_safe_reg   <= cmd.out_seq;
            out_pos_reg    <= cmd.out_seq ? emit_pos_reg : '0;
            out_cust_reg   <= cmd.out_seq ? seq_reg[emit_pos_reg[RW-1:0]] : '0;
            out_last_reg   <= !cmd.out_seq || emit_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_tdata = {2'b00, out_cust_reg, out_pos_reg};
    assign out_tuser = {out_safe_reg, out_status_reg};
    assign out_tlast = out_last_reg;

endmodule

### design/bankers_safety_checker.sv
// Banker's algorithm table with safety check: top level and configuration registers.
//
// Input stream (s_*): one transaction is a command (load maximum, request,
// release) for one customer with an amount per resource. s_tready is high only
// while the block is idle; one item is processed at a time.
// Output stream (m_*): load maximum gives one result. Request and release run
// the safety check and give the safe sequence, one result per active customer,
// or a single result flagged unsafe; m_tlast marks the final result of an item.
// Command code three is taken and gives no result.
// Configuration channel (cfg_*): availability per resource and the number of
// active customers; always ready. The user must write it only while no item is
// in flight; the block itself does not enforce this. Steps: take an item, update
// the tables, then the check visits one customer per cycle, then one result per
// cycle while m_tready stays high.
// Results leave through a one-entry output register; a stall on m_tready holds
// the sequencer until that register drains.
// Reset clears all tables, availability to zero and the active count to eight.
module bankers_safety_checker #(
    parameter int NUM_CUSTOMERS = 8,
    parameter int NUM_RESOURCES = 4,
    parameter int AMOUNT_BITS   = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // customer_index[2:0], amount_r0[10:3], amount_r1[18:11],
    // amount_r2[26:19], amount_r3[34:27], zero fill[39:35]
    input  logic [bsc_pkg::S_TDATA_W-1:0]       s_tdata,
    // command[1:0]
    input  logic [bsc_pkg::S_TUSER_W-1:0]       s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // seq_position[2:0], seq_customer[5:3], zero fill[7:6]
    output logic [bsc_pkg::M_TDATA_W-1:0]       m_tdata,
    // status[1:0], is_safe[2]
    output logic [bsc_pkg::M_TUSER_W-1:0]       m_tuser,
    // last_result
    output logic                                m_tlast,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bsc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [bsc_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int ROWS = (NUM_CUSTOMERS < 8) ? NUM_CUSTOMERS : 8;
    localparam logic [bsc_pkg::CNT_W-1:0] CAP = bsc_pkg::CNT_W'(ROWS);

    bsc_pkg::avail_t                 avail_reg;
    logic [bsc_pkg::CNT_W-1:0]       cust_cnt_reg;
    logic [bsc_pkg::CNT_W-1:0]       active_n;
    bsc_pkg::bsc_cmd_t               cmd;
    bsc_pkg::bsc_stat_t              stat;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            avail_reg    <= '0;
            cust_cnt_reg <= bsc_pkg::CUST_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                bsc_pkg::REG_AVAIL0:    avail_reg[0] <= cfg_data;
                bsc_pkg::REG_AVAIL1:    avail_reg[1] <= cfg_data;
                bsc_pkg::REG_AVAIL2:    avail_reg[2] <= cfg_data;
                bsc_pkg::REG_AVAIL3:    avail_reg[3] <= cfg_data;
                bsc_pkg::REG_CUSTOMERS: cust_cnt_reg <= cfg_data[bsc_pkg::CNT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        if (cust_cnt_reg == '0)
            active_n = bsc_pkg::CNT_W'(1);
        else if (cust_cnt_reg > CAP)
            active_n = CAP;
        else
            active_n = cust_cnt_reg;
    end

    bsc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bsc_datapath #(
        .ROWS          (ROWS),
        .NUM_RESOURCES (NUM_RESOURCES),
        .AMOUNT_BITS   (AMOUNT_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_tdata  (s_tdata),
        .in_tuser  (s_tuser),
        .avail     (avail_reg),
        .active_n  (active_n),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_tdata (m_tdata),
        .out_tuser (m_tuser),
        .out_tlast (m_tlast)
    );

endmodule
